### hdl/vps_pkg.sv
// ----------------------------------------------------------------------------
// vps_pkg
// Shared types, constants and fixed-point helpers for the vertex projection
// pipeline and its matrix unit.
// ----------------------------------------------------------------------------
package vps_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SIZE_WIDTH = 16;

    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = WORD_WIDTH / DIV_PER_STAGE;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    localparam logic [1:0] SEL_MODEL = 2'd0;
    localparam logic [1:0] SEL_VIEW  = 2'd1;
    localparam logic [1:0] SEL_PROJ  = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic signed [WORD_WIDTH-1:0] q_t;
    typedef q_t [15:0] mat_t;
    typedef q_t [3:0]  vec4_t;

    localparam q_t Q_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam q_t Q_ONE = q_t'(1) <<< FRAC_BITS;

    localparam logic [2*WORD_WIDTH-1:0] MIN_MAG = (2*WORD_WIDTH)'(1) << (WORD_WIDTH - 1);
    localparam logic [2*WORD_WIDTH-1:0] MAX_MAG = MIN_MAG - 1'b1;
    localparam logic [2*WORD_WIDTH-1:0] HALF_LSB = (2*WORD_WIDTH)'(1) << (FRAC_BITS - 1);

    localparam logic signed [WORD_WIDTH+1:0] WIDE_MAX = {3'b000, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [WORD_WIDTH+1:0] WIDE_MIN = {3'b111, {(WORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic       operation;
        logic [1:0] matrix_select;
        logic [3:0] entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth;
        logic signed [31:0] clip_w;
    } out_word_t;

    typedef struct packed {
        logic       load_en;
        logic [1:0] sel;
        logic [3:0] idx;
        q_t         value;
        logic       vertex_wait;
    } mat_ctrl_t;

    typedef struct packed {
        logic busy;
        logic stale;
    } mat_stat_t;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] ud;
        logic [WORD_WIDTH-1:0] rem;
        logic [WORD_WIDTH-1:0] num;
        logic [WORD_WIDTH-1:0] quo;
        logic                  neg;
        logic                  ovf;
    } div_lane_t;

    function automatic logic [WORD_WIDTH-1:0] mag_of(input q_t v);
        logic [WORD_WIDTH-1:0] u;
        u = v;
        return v[WORD_WIDTH-1] ? (~u + 1'b1) : u;
    endfunction

    // signed result from a magnitude, clamped to the word range
    function automatic q_t apply_sign(input logic [2*WORD_WIDTH-1:0] m, input logic neg);
        q_t res;
        if (neg) begin
            res = (m > MIN_MAG) ? Q_MIN : q_t'(~m[WORD_WIDTH-1:0] + 1'b1);
        end else begin
            res = (m > MAX_MAG) ? Q_MAX : q_t'(m[WORD_WIDTH-1:0]);
        end
        return res;
    endfunction

    // round to nearest, ties away from zero, at the fraction point
    function automatic q_t round_prod(input logic signed [2*WORD_WIDTH-1:0] p);
        logic [2*WORD_WIDTH-1:0] pu;
        logic [2*WORD_WIDTH-1:0] m;
        logic [2*WORD_WIDTH-1:0] r;
        pu = p;
        m  = p[2*WORD_WIDTH-1] ? (~pu + 1'b1) : pu;
        r  = (m + HALF_LSB) >> FRAC_BITS;
        return apply_sign(r, p[2*WORD_WIDTH-1]);
    endfunction

    function automatic q_t sat_wide(input logic signed [WORD_WIDTH+1:0] s);
        q_t res;
        if (s > WIDE_MAX) begin
            res = Q_MAX;
        end else if (s < WIDE_MIN) begin
            res = Q_MIN;
        end else begin
            res = q_t'(s[WORD_WIDTH-1:0]);
        end
        return res;
    endfunction

    // one restoring quotient bit
    function automatic div_lane_t div_step(input div_lane_t l);
        div_lane_t o;
        logic [WORD_WIDTH:0] rs;
        logic [WORD_WIDTH:0] diff;
        logic                ge;
        o    = l;
        rs   = {l.rem, l.num[WORD_WIDTH-1]};
        diff = rs - {1'b0, l.ud};
        ge   = (rs >= {1'b0, l.ud});
        o.rem = ge ? diff[WORD_WIDTH-1:0] : rs[WORD_WIDTH-1:0];
        o.num = {l.num[WORD_WIDTH-2:0], 1'b0};
        o.quo = {l.quo[WORD_WIDTH-2:0], ge};
        return o;
    endfunction

    // quotient bits of one pipeline stage
    function automatic div_lane_t div_stage(input div_lane_t l);
        div_lane_t o;
        o = l;
        for (int k = 0; k < DIV_PER_STAGE; k++) begin
            o = div_step(o);
        end
        return o;
    endfunction

endpackage

### hdl/vps_matrix_unit.sv
// ----------------------------------------------------------------------------
// vps_matrix_unit
// Holds the model, view and projection matrices and rebuilds the cached
// combined matrix with one shared multiplier after loads.
// ----------------------------------------------------------------------------
module vps_matrix_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  vps_pkg::mat_ctrl_t ctrl,
    output vps_pkg::mat_stat_t stat,
    output vps_pkg::mat_t      mvp
);
    import vps_pkg::*;

    localparam logic [7:0] ISSUE_END   = 8'd128;
    localparam logic [7:0] ENGINE_LAST = 8'd129;

    q_t model_reg [16];
    q_t view_reg  [16];
    q_t proj_reg  [16];
    q_t mv_reg    [16];
    mat_t mvp_reg;

    logic       busy_reg;
    logic       stale_reg;
    logic [7:0] cnt_reg;
    logic       start;
    logic       issue;
    logic [3:0] a_idx;
    logic [3:0] b_idx;
    q_t         op_a;
    q_t         op_b;

    logic signed [2*WORD_WIDTH-1:0] prod_reg;
    logic       a_vld_reg, a_first_reg, a_last_reg, a_phase_reg;
    logic [3:0] a_dest_reg;
    q_t         q_reg;
    logic       b_vld_reg, b_first_reg, b_last_reg, b_phase_reg;
    logic [3:0] b_dest_reg;
    logic signed [WORD_WIDTH+1:0] acc_reg;
    logic signed [WORD_WIDTH+1:0] acc_next;

    assign start = ctrl.vertex_wait && stale_reg && !busy_reg;
    assign issue = busy_reg && (cnt_reg < ISSUE_END);
    assign a_idx = {cnt_reg[1:0], cnt_reg[3:2]};
    assign b_idx = {cnt_reg[5:4], cnt_reg[1:0]};
    assign op_a  = cnt_reg[6] ? mv_reg[a_idx] : model_reg[a_idx];
    assign op_b  = cnt_reg[6] ? proj_reg[b_idx] : view_reg[b_idx];
    assign acc_next = (b_first_reg ? '0 : acc_reg) + (WORD_WIDTH+2)'(q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            stale_reg <= 1'b0;
            cnt_reg   <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= issue;
            b_vld_reg <= a_vld_reg;
            if (ctrl.load_en) begin
                stale_reg <= 1'b1;
            end
            if (start) begin
                busy_reg  <= 1'b1;
                stale_reg <= 1'b0;
                cnt_reg   <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ENGINE_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_en) begin
            unique case (ctrl.sel)
                SEL_MODEL: model_reg[ctrl.idx] <= ctrl.value;
                SEL_VIEW:  view_reg[ctrl.idx]  <= ctrl.value;
                SEL_PROJ:  proj_reg[ctrl.idx]  <= ctrl.value;
                default: ;
            endcase
        end
        prod_reg    <= (2*WORD_WIDTH)'(op_a) * (2*WORD_WIDTH)'(op_b);
        a_first_reg <= (cnt_reg[1:0] == 2'd0);
        a_last_reg  <= (cnt_reg[1:0] == 2'd3);
        a_phase_reg <= cnt_reg[6];
        a_dest_reg  <= {cnt_reg[5:4], cnt_reg[3:2]};
        q_reg       <= round_prod(prod_reg);
        b_first_reg <= a_first_reg;
        b_last_reg  <= a_last_reg;
        b_phase_reg <= a_phase_reg;
        b_dest_reg  <= a_dest_reg;
        if (b_vld_reg) begin
            acc_reg <= acc_next;
            if (b_last_reg) begin
                if (b_phase_reg) begin
                    mvp_reg[b_dest_reg] <= sat_wide(acc_next);
                end else begin
                    mv_reg[b_dest_reg] <= sat_wide(acc_next);
                end
            end
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.stale = stale_reg;
    assign mvp        = mvp_reg;

endmodule

### hdl/vps_divider.sv
// ----------------------------------------------------------------------------
// vps_divider
// Pipelined perspective divide of x, y and z by clip w, two quotient bits
// per stage, truncating and saturating.
// ----------------------------------------------------------------------------
module vps_divider (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  vps_pkg::vec4_t in_c,
    output logic           out_valid,
    output vps_pkg::vec4_t out_c
);
    import vps_pkg::*;

    div_lane_t lane_reg [DIV_STAGES+1][3];
    logic      vld_reg  [DIV_STAGES+1];
    logic      pass_reg [DIV_STAGES+1];
    vec4_t     c_reg    [DIV_STAGES+1];
    div_lane_t setup    [3];
    logic      out_valid_reg;
    vec4_t     out_c_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [WORD_WIDTH-1:0] un;
            logic [WORD_WIDTH-1:0] hi;
            un = mag_of(in_c[l]);
            hi = un >> (WORD_WIDTH - FRAC_BITS);
            setup[l].ud  = mag_of(in_c[3]);
            setup[l].ovf = (hi >= mag_of(in_c[3]));
            setup[l].rem = (hi >= mag_of(in_c[3])) ? '0 : hi;
            setup[l].num = un << FRAC_BITS;
            setup[l].quo = '0;
            setup[l].neg = in_c[l][WORD_WIDTH-1] ^ in_c[3][WORD_WIDTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                vld_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            out_valid_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                lane_reg[0][l] <= setup[l];
            end
            pass_reg[0] <= (in_c[3] == '0);
            c_reg[0]    <= in_c;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                for (int l = 0; l < 3; l++) begin
                    lane_reg[s][l] <= div_stage(lane_reg[s-1][l]);
                end
                pass_reg[s] <= pass_reg[s-1];
                c_reg[s]    <= c_reg[s-1];
            end
            for (int l = 0; l < 3; l++) begin
                if (pass_reg[DIV_STAGES]) begin
                    out_c_reg[l] <= c_reg[DIV_STAGES][l];
                end else if (lane_reg[DIV_STAGES][l].ovf) begin
                    out_c_reg[l] <= lane_reg[DIV_STAGES][l].neg ? Q_MIN : Q_MAX;
                end else begin
                    out_c_reg[l] <= apply_sign((2*WORD_WIDTH)'(lane_reg[DIV_STAGES][l].quo),
                                               lane_reg[DIV_STAGES][l].neg);
                end
            end
            out_c_reg[3] <= c_reg[DIV_STAGES][3];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_c     = out_c_reg;

endmodule

### hdl/vertex_project_to_screen.sv
// ----------------------------------------------------------------------------
// vertex_project_to_screen
// Fixed-point vertex transform by the cached model-view-projection matrix,
// perspective divide and viewport mapping.
// ----------------------------------------------------------------------------
//  channel  ports                          word
//  in       s_valid s_ready s_data         matrix entry load or vertex
//  out      m_valid m_ready m_data         screen x, y, depth, clip w
//  config   cfg_we cfg_index cfg_data      viewport width, height
//
//  one word per cycle unless the output stalls or a rebuild of the combined matrix is due or running
//  after loads, the first vertex waits while the shared multiplier
//  of the matrix unit rebuilds the combined matrix (128 products)
//  synchronous reset clears valid bits and sets the viewport to 640 x 480
//  a stalled output holds the whole pipeline; nothing is dropped
// ----------------------------------------------------------------------------
module vertex_project_to_screen (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vps_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vps_pkg::out_word_t m_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import vps_pkg::*;

    logic [SIZE_WIDTH-1:0] width_reg;
    logic [SIZE_WIDTH-1:0] height_reg;

    mat_ctrl_t mctrl;
    mat_stat_t mstat;
    mat_t      mvp;

    logic adv;
    logic accept;
    q_t   pt [3];

    logic signed [2*WORD_WIDTH-1:0] prod_reg [4][3];
    q_t    wcol1_reg [4];
    q_t    q_reg     [4][3];
    q_t    wcol2_reg [4];
    vec4_t c_reg;
    logic  v1_reg, v2_reg, v3_reg;

    logic  dv;
    vec4_t dc;

    q_t    sx_reg, sy_reg, z1_reg, w1_reg;
    logic  va_reg;
    logic [WORD_WIDTH+SIZE_WIDTH-1:0] px_reg, py_reg;
    logic  nx_reg, ny_reg;
    q_t    z2_reg, w2_reg;
    logic  vb_reg;

    logic      m_valid_reg;
    out_word_t m_data_reg;
    logic [WORD_WIDTH+SIZE_WIDTH-1:0] rx, ry;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && !mstat.busy &&
                     !(mstat.stale && s_valid && (s_data.operation == OP_VERTEX));
    assign accept  = s_valid && s_ready;

    assign mctrl.load_en     = accept && (s_data.operation == OP_LOAD);
    assign mctrl.sel         = s_data.matrix_select;
    assign mctrl.idx         = s_data.entry_index;
    assign mctrl.value       = q_t'(s_data.entry_value);
    assign mctrl.vertex_wait = s_valid && (s_data.operation == OP_VERTEX);

    vps_matrix_unit u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mctrl),
        .stat    (mstat),
        .mvp     (mvp)
    );

    assign pt[0] = q_t'(s_data.point_x);
    assign pt[1] = q_t'(s_data.point_y);
    assign pt[2] = q_t'(s_data.point_z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_WIDTH'(640);
            height_reg <= SIZE_WIDTH'(480);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= accept && (s_data.operation == OP_VERTEX);
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            va_reg      <= dv;
            vb_reg      <= va_reg;
            m_valid_reg <= vb_reg;
        end
    end

    always_comb begin
        rx = (px_reg >> 1) + (WORD_WIDTH+SIZE_WIDTH)'(px_reg[0]);
        ry = (py_reg >> 1) + (WORD_WIDTH+SIZE_WIDTH)'(py_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= (2*WORD_WIDTH)'(mvp[i+4*j]) * (2*WORD_WIDTH)'(pt[j]);
                    q_reg[i][j]    <= round_prod(prod_reg[i][j]);
                end
                wcol1_reg[i] <= mvp[i+12];
                wcol2_reg[i] <= wcol1_reg[i];
                c_reg[i] <= sat_wide((WORD_WIDTH+2)'(q_reg[i][0]) +
                                     (WORD_WIDTH+2)'(q_reg[i][1]) +
                                     (WORD_WIDTH+2)'(q_reg[i][2]) +
                                     (WORD_WIDTH+2)'(wcol2_reg[i]));
            end
            sx_reg <= sat_wide((WORD_WIDTH+2)'(dc[0]) + (WORD_WIDTH+2)'(Q_ONE));
            sy_reg <= sat_wide((WORD_WIDTH+2)'(Q_ONE) - (WORD_WIDTH+2)'(dc[1]));
            z1_reg <= dc[2];
            w1_reg <= dc[3];
            px_reg <= (WORD_WIDTH+SIZE_WIDTH)'(mag_of(sx_reg)) *
                      (WORD_WIDTH+SIZE_WIDTH)'(width_reg);
            py_reg <= (WORD_WIDTH+SIZE_WIDTH)'(mag_of(sy_reg)) *
                      (WORD_WIDTH+SIZE_WIDTH)'(height_reg);
            nx_reg <= sx_reg[WORD_WIDTH-1];
            ny_reg <= sy_reg[WORD_WIDTH-1];
            z2_reg <= z1_reg;
            w2_reg <= w1_reg;
            m_data_reg.screen_x <= 32'(apply_sign((2*WORD_WIDTH)'(rx), nx_reg));
            m_data_reg.screen_y <= 32'(apply_sign((2*WORD_WIDTH)'(ry), ny_reg));
            m_data_reg.depth    <= 32'(z2_reg);
            m_data_reg.clip_w   <= 32'(w2_reg);
        end
    end

    vps_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_c      (c_reg),
        .out_valid (dv),
        .out_c     (dc)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### dv/vertex_project_to_screen_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_project_to_screen_checker
// Watches the word and result channels of the vertex projection block, keeps
// its own copy of the three matrices and the viewport, predicts the screen
// result of every vertex and compares it field by field with the block.
// ----------------------------------------------------------------------------
module vertex_project_to_screen_checker
    import vps_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data,
    output int        fail_count,
    output int        pending_count
);

    typedef longint signed qv_t;
    typedef qv_t mat16_t [16];

    localparam qv_t QV_MAX = 64'sd2147483647;
    localparam qv_t QV_MIN = -64'sd2147483648;
    localparam qv_t QV_ONE = 64'sd65536;

    logic signed [31:0] model_m [16];
    logic signed [31:0] view_m  [16];
    logic signed [31:0] proj_m  [16];
    longint unsigned vp_width;
    longint unsigned vp_height;
    out_word_t screen_queue [$];

    assign pending_count = screen_queue.size();

    function automatic qv_t clamp_q(qv_t v);
        if (v > QV_MAX) return QV_MAX;
        if (v < QV_MIN) return QV_MIN;
        return v;
    endfunction

    function automatic qv_t limit_mag(logic [127:0] m, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (m > lim) m = lim;
        return neg ? -qv_t'(m[63:0]) : qv_t'(m[63:0]);
    endfunction

    function automatic qv_t fx_mul(qv_t a, qv_t b);
        logic [127:0] p;
        bit neg;
        neg = (a < 0) != (b < 0);
        p = 128'((a < 0) ? -a : a) * 128'((b < 0) ? -b : b);
        p = (p + 128'd32768) >> FRAC_BITS;
        return limit_mag(p, neg);
    endfunction

    function automatic qv_t fx_div(qv_t n, qv_t d);
        logic [127:0] un, ud, q;
        bit neg;
        neg = (n < 0) != (d < 0);
        un = 128'((n < 0) ? -n : n);
        ud = 128'((d < 0) ? -d : d);
        q = (un << FRAC_BITS) / ud;
        return limit_mag(q, neg);
    endfunction

    function automatic qv_t half_size(qv_t s, longint unsigned size);
        logic [127:0] m;
        m = 128'((s < 0) ? -s : s) * 128'(size);
        m = (m >> 1) + (m & 1);
        return limit_mag(m, s < 0);
    endfunction

    function automatic mat16_t mat_product(mat16_t a, mat16_t b);
        mat16_t r;
        qv_t acc;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) acc += fx_mul(a[i+4*k], b[k+4*j]);
                r[i+4*j] = clamp_q(acc);
            end
        return r;
    endfunction

    function automatic out_word_t project_vertex(in_word_t w);
        mat16_t ma, va, pa, mvp;
        qv_t pt [4];
        qv_t c [4];
        qv_t acc;
        out_word_t r;
        for (int i = 0; i < 16; i++) begin
            ma[i] = model_m[i];
            va[i] = view_m[i];
            pa[i] = proj_m[i];
        end
        mvp = mat_product(mat_product(ma, va), pa);
        pt[0] = w.point_x;
        pt[1] = w.point_y;
        pt[2] = w.point_z;
        pt[3] = QV_ONE;
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) acc += fx_mul(mvp[i+4*j], pt[j]);
            c[i] = clamp_q(acc);
        end
        if (c[3] != 0) begin
            for (int i = 0; i < 3; i++) c[i] = fx_div(c[i], c[3]);
        end
        r.screen_x = 32'(half_size(clamp_q(c[0] + QV_ONE), vp_width));
        r.screen_y = 32'(half_size(clamp_q(QV_ONE - c[1]), vp_height));
        r.depth    = 32'(c[2]);
        r.clip_w   = 32'(c[3]);
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t exp_w;
        if (!aresetn) begin
            vp_width  <= 640;
            vp_height <= 480;
            fail_count <= 0;
            screen_queue.delete();
            for (int i = 0; i < 16; i++) begin
                model_m[i] = 0;
                view_m[i]  = 0;
                proj_m[i]  = 0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_WIDTH) vp_width <= cfg_data;
                else vp_height <= cfg_data;
            end
            if (s_valid && s_ready) begin
                if (s_data.operation == OP_LOAD) begin
                    case (s_data.matrix_select)
                        SEL_MODEL: model_m[s_data.entry_index] = s_data.entry_value;
                        SEL_VIEW:  view_m[s_data.entry_index]  = s_data.entry_value;
                        SEL_PROJ:  proj_m[s_data.entry_index]  = s_data.entry_value;
                        default: ;
                    endcase
                end else begin
                    screen_queue.push_back(project_vertex(s_data));
                end
            end
            if (m_valid && m_ready) begin
                if (screen_queue.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = screen_queue.pop_front();
                    if (exp_w !== m_data) begin
                        $display("%0t: mismatch expected x %h y %h d %h w %h",
                                 $time, exp_w.screen_x, exp_w.screen_y,
                                 exp_w.depth, exp_w.clip_w);
                        $display("%0t:          actual   x %h y %h d %h w %h",
                                 $time, m_data.screen_x, m_data.screen_y,
                                 m_data.depth, m_data.clip_w);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/vertex_project_to_screen_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_project_to_screen_tb
// Loads matrices and streams vertices through the projection block under
// several idle and stall patterns and viewport sizes; a checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module vertex_project_to_screen_tb;
    import vps_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    logic      cfg_we = 1'b0;
    logic      cfg_index = REG_WIDTH;
    logic [15:0] cfg_data = '0;
    int        fail_count;
    int        pending_count;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_off = 1'b0;

    always #10 aclk = ~aclk;

    vertex_project_to_screen i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vertex_project_to_screen_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver
    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom);
            default: return 32'($signed($urandom_range(262144)) - 131072);
        endcase
    endfunction

    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic load_entry(logic [1:0] sel, logic [3:0] idx, logic signed [31:0] v);
        in_word_t w;
        w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.operation     = OP_LOAD;
        w.matrix_select = sel;
        w.entry_index   = idx;
        w.entry_value   = v;
        send_word(w);
    endtask

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        in_word_t w;
        w = in_word_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.operation = OP_VERTEX;
        w.point_x = x;
        w.point_y = y;
        w.point_z = z;
        send_word(w);
    endtask

    // matrix with small random entries and identity-like diagonal, or wild random entries
    task automatic load_matrix(logic [1:0] sel, bit wild);
        for (int i = 0; i < 16; i++)
            load_entry(sel, 4'(i), wild ? rand_q()
                       : ((i % 5 == 0) ? 32'sd65536 : 32'($signed($urandom_range(32768)) - 16384)));
    endtask

    task automatic set_viewport(logic [15:0] w, logic [15:0] h);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we <= 1'b1; cfg_index <= REG_WIDTH; cfg_data <= w;
        @(posedge aclk);
        cfg_index <= REG_HEIGHT; cfg_data <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int kind;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity matrices, extremes, zero w, ignored selector, viewport extremes
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < 16; i++)
                load_entry(2'(s), 4'(i), (i % 5 == 0) ? 32'sd65536 : 32'sd0);
        send_vertex(0, 0, 0);
        send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        load_entry(2'd3, 4'd15, 32'sh12345678);
        load_entry(SEL_PROJ, 4'd15, 32'sd0);
        send_vertex(32'sd65536, -32'sd65536, 32'sd32768);
        load_entry(SEL_PROJ, 4'd15, 32'sd131072);
        load_entry(SEL_PROJ, 4'd11, 32'sd65536);
        send_vertex(32'sd100000, 32'sd200000, -32'sd300000);
        set_viewport(16'd0, 16'd65535);
        send_vertex(32'sd65536, 32'sd65536, 32'sd65536);
        set_viewport(16'd65535, 16'd1);
        send_vertex(-32'sd7, 32'sd9, 32'sd65536);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (phase == 4) set_viewport(16'd1, 16'd1);
            else if (phase == 6) set_viewport(16'($urandom), 16'($urandom));
            else if (phase == 7) set_viewport(16'd640, 16'd480);
            for (int s = 0; s < 3; s++) load_matrix(2'(s), phase == 5);
            for (int n = 0; n < 140; n++) begin
                kind = $urandom_range(19);
                if (kind == 0) load_entry(2'($urandom), 4'($urandom), rand_q());
                else if (kind == 1) load_entry(2'($urandom_range(2)), 4'($urandom),
                                               32'($signed($urandom_range(131072)) - 65536));
                else send_vertex(rand_q(), rand_q(), rand_q());
            end
        end

        // long receiver hold-off while words keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 80; n++) send_vertex(rand_q(), rand_q(), rand_q());
        join
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
hdl/vps_pkg.sv
hdl/vps_matrix_unit.sv
hdl/vps_divider.sv
hdl/vertex_project_to_screen.sv
dv/vertex_project_to_screen_checker.sv
dv/vertex_project_to_screen_tb.sv
